/* rtl/core/mkf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkf_pkg - shared constants for the multi-channel scalar kalman filter
// Field widths, fixed-point formats and register indexes used by the filter
// core, its serial divider and its serial multiplier.
// ----------------------------------------------------------------------------
package mkf_pkg;

   localparam int CHANNELS    = 6;
   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_BITS   = 16;

   localparam int CH_BITS  = 3;
   localparam int EST_BITS = 32;
   localparam int VAR_BITS = 20;
   localparam int IDX_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 20;

   // gain carries one integer bit so that 1.0 is exact
   localparam int K_BITS    = FRAC_BITS + 1;
   localparam int DEN_BITS  = VAR_BITS + 1;
   localparam int REM_BITS  = VAR_BITS + 2;
   localparam int DIFF_BITS = EST_BITS + 1;
   localparam int PE_BITS   = DIFF_BITS + K_BITS;
   localparam int PV_BITS   = VAR_BITS + K_BITS;
   localparam int CNT_BITS  = $clog2(K_BITS + 1);

   localparam logic [VAR_BITS-1:0] VAR_MAX = {VAR_BITS{1'b1}};
   localparam logic [EST_BITS-1:0] EST_MAX = {1'b0, {(EST_BITS-1){1'b1}}};
   localparam logic [EST_BITS-1:0] EST_MIN = {1'b1, {(EST_BITS-1){1'b0}}};

   localparam logic [CSR_IDX_BITS-1:0] REG_PROCESS_NOISE     = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_MEASUREMENT_NOISE = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_INITIAL_VARIANCE  = 2'd2;

   localparam logic [CSR_DATA_BITS-1:0] RST_PROCESS_NOISE     = 20'd6554;
   localparam logic [CSR_DATA_BITS-1:0] RST_MEASUREMENT_NOISE = 20'd6554;
   localparam logic [CSR_DATA_BITS-1:0] RST_INITIAL_VARIANCE  = 20'd65536;

endpackage

/* rtl/core/mkf_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkf_divider - bit-serial gain divider
// Restoring division k = floor(p * 2^F / d), one quotient bit per cycle,
// K_BITS quotient bits, then a done pulse. A zero divisor gives a zero gain.
// ----------------------------------------------------------------------------
module mkf_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [mkf_pkg::VAR_BITS-1:0]  p,
   input  logic [mkf_pkg::DEN_BITS-1:0]  d,
   output logic                          done,
   output logic [mkf_pkg::K_BITS-1:0]    k
);
   import mkf_pkg::*;

   logic [REM_BITS-1:0] rem_ff, rem_in;
   logic [DEN_BITS-1:0] den_ff, den_in;
   logic [K_BITS-1:0]   quo_ff, quo_in;
   logic                zero_ff, zero_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;

   logic                ge;
   logic [REM_BITS-1:0] rem_sub;

   assign ge      = rem_ff >= REM_BITS'(den_ff);
   assign rem_sub = rem_ff - REM_BITS'(den_ff);

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      zero_in = zero_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = REM_BITS'(p);
         den_in  = d;
         quo_in  = '0;
         zero_in = (d == '0);
         cnt_in  = CNT_BITS'(K_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // remainder stays below 2d, so the shifted value fits
         rem_in = (ge ? rem_sub : rem_ff) << 1;
         quo_in = {quo_ff[K_BITS-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
      zero_ff <= zero_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign k    = zero_ff ? '0 : quo_ff;

endmodule

/* rtl/core/mkf_multiplier.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkf_multiplier - bit-serial shift-add multiplier pair
// Forms k * (z - x) and (1 - k) * p together, one gain bit per cycle,
// then raises done once all K_BITS gain bits are used.
// ----------------------------------------------------------------------------
module mkf_multiplier (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [mkf_pkg::DIFF_BITS-1:0] diff,
   input  logic        [mkf_pkg::K_BITS-1:0]    k,
   input  logic        [mkf_pkg::VAR_BITS-1:0]  p,
   output logic                                 done,
   output logic signed [mkf_pkg::PE_BITS-1:0]   prod_est,
   output logic        [mkf_pkg::PV_BITS-1:0]   prod_var
);
   import mkf_pkg::*;

   localparam logic [K_BITS-1:0] ONE = K_BITS'(1) << FRAC_BITS;

   logic signed [PE_BITS-1:0] mce_ff, mce_in;
   logic signed [PE_BITS-1:0] acce_ff, acce_in;
   logic        [PV_BITS-1:0] mcv_ff, mcv_in;
   logic        [PV_BITS-1:0] accv_ff, accv_in;
   logic        [K_BITS-1:0]  ke_ff, ke_in;
   logic        [K_BITS-1:0]  kv_ff, kv_in;
   logic        [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;

   always_comb begin
      mce_in  = mce_ff;
      acce_in = acce_ff;
      mcv_in  = mcv_ff;
      accv_in = accv_ff;
      ke_in   = ke_ff;
      kv_in   = kv_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         mce_in  = PE_BITS'(diff);
         acce_in = '0;
         mcv_in  = PV_BITS'(p);
         accv_in = '0;
         ke_in   = k;
         kv_in   = ONE - k;
         cnt_in  = CNT_BITS'(K_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (ke_ff[0]) begin
            acce_in = acce_ff + mce_ff;
         end
         if (kv_ff[0]) begin
            accv_in = accv_ff + mcv_ff;
         end
         mce_in = mce_ff <<< 1;
         mcv_in = mcv_ff << 1;
         ke_in  = ke_ff >> 1;
         kv_in  = kv_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      mce_ff  <= mce_in;
      acce_ff <= acce_in;
      mcv_ff  <= mcv_in;
      accv_ff <= accv_in;
      ke_ff   <= ke_in;
      kv_ff   <= kv_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign prod_est = acce_ff;
   assign prod_var = accv_ff;

endmodule

/* rtl/core/multi_channel_scalar_kalman_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_scalar_kalman_filter - six-channel scalar kalman filter
// Per-channel estimate and variance, predict and update on every sample.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one item is a channel number and a signed raw sample, taken
//   when req_valid is high and req_stall is low. rsp_ channel: one item per
//   request with the channel, the new estimate (Q16.16) and variance (Q4.16).
//   csr_ port: write process noise, measurement noise and initial variance
//   while the filter is idle; unknown indexes are dropped.
//   From request accept to rsp_valid an item passes predict, the bit-serial
//   divider, the bit-serial multipliers, rounding and write-back.
//   An out-of-range channel skips the divider and multipliers and returns
//   zeros. One item is in flight at a time: no new request is taken until
//   the core is back in idle.
//   The result sits in an output register: a new request is taken while a
//   stalled result waits, and the core holds its write-back until the
//   output register is free. Reset clears the seen flags, so each channel's
//   next sample loads its estimate and initial variance; registers return
//   to their reset values.
// ----------------------------------------------------------------------------
module multi_channel_scalar_kalman_filter (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic        [mkf_pkg::CH_BITS-1:0]     req_channel,
   input  logic signed [mkf_pkg::SAMPLE_BITS-1:0] req_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic        [mkf_pkg::CH_BITS-1:0]     rsp_channel_out,
   output logic signed [mkf_pkg::EST_BITS-1:0]    rsp_estimate,
   output logic        [mkf_pkg::VAR_BITS-1:0]    rsp_variance,
   input  logic                                   csr_wr_en,
   input  logic        [mkf_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic        [mkf_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import mkf_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_PRED = 6'b000010,
      S_DIV  = 6'b000100,
      S_MUL  = 6'b001000,
      S_RND  = 6'b010000,
      S_DONE = 6'b100000
   } state_type;

   localparam int Z_WIDE   = SAMPLE_BITS + FRAC_BITS;
   localparam int ZX_BITS  = ((Z_WIDE > EST_BITS) ? Z_WIDE : EST_BITS) + 1;
   localparam int DLT_BITS = PE_BITS - FRAC_BITS;
   localparam int SUM_BITS = DLT_BITS + 1;
   localparam int NP_BITS  = PV_BITS + 1 - FRAC_BITS;

   localparam logic [PE_BITS-1:0] HALF_E = PE_BITS'(1) << (FRAC_BITS - 1);
   localparam logic [PV_BITS:0]   HALF_V = (PV_BITS + 1)'(1) << (FRAC_BITS - 1);

   state_type state_ff, state_in;

   logic [VAR_BITS-1:0] q_ff, r_ff, p0_ff;

   logic        [EST_BITS-1:0] est_ff [CHANNELS];
   logic        [VAR_BITS-1:0] var_ff [CHANNELS];
   logic        [CHANNELS-1:0] seen_ff;

   logic        [CH_BITS-1:0]     ch_ff;
   logic signed [SAMPLE_BITS-1:0] smp_ff;
   logic signed [EST_BITS-1:0]    x_ff, x_in;
   logic signed [EST_BITS-1:0]    z_ff, z_in;
   logic        [VAR_BITS-1:0]    p_ff, p_in;
   logic signed [DLT_BITS-1:0]    delta_ff, delta_in;
   logic        [VAR_BITS-1:0]    np_ff, np_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic        [CH_BITS-1:0]  rsp_ch_ff;
   logic signed [EST_BITS-1:0] rsp_est_ff, rsp_est_in;
   logic        [VAR_BITS-1:0] rsp_var_ff, rsp_var_in;

   logic                 req_fire, out_free, retire, in_range;
   logic [IDX_BITS-1:0]  idx;

   logic signed [ZX_BITS-1:0]          z_ext;
   logic        [ZX_BITS-EST_BITS:0]   z_hi;
   logic        [VAR_BITS-1:0]         p_cur;
   logic        [VAR_BITS:0]           p_sum;
   logic        [VAR_BITS-1:0]         p_pred;
   logic        [DEN_BITS-1:0]         den;

   logic                         div_start, div_done, mul_start, mul_done;
   logic        [K_BITS-1:0]     gain;
   logic signed [DIFF_BITS-1:0]  diff;
   logic signed [PE_BITS-1:0]    prod_est, rnd_e;
   logic        [PV_BITS-1:0]    prod_var;
   logic        [PV_BITS:0]      rnd_v;
   logic        [NP_BITS-1:0]    np_full;
   logic signed [SUM_BITS-1:0]   x_sum;
   logic        [SUM_BITS-EST_BITS:0] sum_hi;

   assign req_fire = req_valid && (state_ff == S_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign retire   = (state_ff == S_DONE) && out_free;
   assign in_range = ({1'b0, ch_ff} < (CH_BITS + 1)'(CHANNELS));
   assign idx      = ch_ff[IDX_BITS-1:0];

   // measurement z = sample * 2^F, saturated to the estimate width
   assign z_ext = ZX_BITS'(smp_ff) <<< FRAC_BITS;
   assign z_hi  = z_ext[ZX_BITS-1:EST_BITS-1];
   always_comb begin
      if (&z_hi || ~|z_hi) begin
         z_in = z_ext[EST_BITS-1:0];
      end else begin
         z_in = z_ext[ZX_BITS-1] ? EST_MIN : EST_MAX;
      end
   end

   // first sample on a channel loads the estimate and the initial variance
   assign x_in   = seen_ff[idx] ? est_ff[idx] : z_in;
   assign p_cur  = seen_ff[idx] ? var_ff[idx] : p0_ff;
   assign p_sum  = {1'b0, p_cur} + {1'b0, q_ff};
   assign p_pred = p_sum[VAR_BITS] ? VAR_MAX : p_sum[VAR_BITS-1:0];
   assign p_in   = p_pred;
   assign den    = {1'b0, p_pred} + {1'b0, r_ff};

   assign div_start = (state_ff == S_PRED) && in_range;
   assign mul_start = (state_ff == S_DIV) && div_done;
   assign diff      = DIFF_BITS'(z_ff) - DIFF_BITS'(x_ff);

   mkf_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .p     (p_pred),
      .d     (den),
      .done  (div_done),
      .k     (gain)
   );

   mkf_multiplier u_mul (
      .clock    (clock),
      .reset    (reset),
      .start    (mul_start),
      .diff     (diff),
      .k        (gain),
      .p        (p_ff),
      .done     (mul_done),
      .prod_est (prod_est),
      .prod_var (prod_var)
   );

   // round half up, then drop the fraction
   assign rnd_e    = prod_est + HALF_E;
   assign delta_in = rnd_e[PE_BITS-1:FRAC_BITS];
   assign rnd_v    = {1'b0, prod_var} + HALF_V;
   assign np_full  = rnd_v[PV_BITS:FRAC_BITS];
   assign np_in    = (|np_full[NP_BITS-1:VAR_BITS]) ? VAR_MAX : np_full[VAR_BITS-1:0];

   assign x_sum  = SUM_BITS'(x_ff) + SUM_BITS'(delta_ff);
   assign sum_hi = x_sum[SUM_BITS-1:EST_BITS-1];

   always_comb begin
      if (!in_range) begin
         rsp_est_in = '0;
      end else if (&sum_hi || ~|sum_hi) begin
         rsp_est_in = x_sum[EST_BITS-1:0];
      end else begin
         rsp_est_in = x_sum[SUM_BITS-1] ? EST_MIN : EST_MAX;
      end
      rsp_var_in = in_range ? np_ff : '0;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_PRED;
            end
         end
         S_PRED: begin
            state_in = in_range ? S_DIV : S_DONE;
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            if (mul_done) begin
               state_in = S_RND;
            end
         end
         S_RND: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (retire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         q_ff         <= RST_PROCESS_NOISE;
         r_ff         <= RST_MEASUREMENT_NOISE;
         p0_ff        <= RST_INITIAL_VARIANCE;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               REG_PROCESS_NOISE:     q_ff  <= csr_wdata;
               REG_MEASUREMENT_NOISE: r_ff  <= csr_wdata;
               REG_INITIAL_VARIANCE:  p0_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         ch_ff  <= req_channel;
         smp_ff <= req_sample;
      end
      if (state_ff == S_PRED) begin
         x_ff <= x_in;
         z_ff <= z_in;
         p_ff <= p_in;
      end
      if (state_ff == S_RND) begin
         delta_ff <= delta_in;
         np_ff    <= np_in;
      end
      if (retire) begin
         rsp_ch_ff  <= ch_ff;
         rsp_est_ff <= rsp_est_in;
         rsp_var_ff <= rsp_var_in;
      end
   end

   // per-channel state, written back when the item retires
   always_ff @(posedge clock) begin
      if (retire && in_range) begin
         est_ff[idx] <= rsp_est_in;
         var_ff[idx] <= rsp_var_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else if (retire && in_range) begin
         seen_ff[idx] <= 1'b1;
      end
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_channel_out = rsp_ch_ff;
   assign rsp_estimate    = rsp_est_ff;
   assign rsp_variance    = rsp_var_ff;

endmodule
